// ----- sv/fmsp_pkg.sv -----
package fmsp_pkg;

   // Depth of the queue between the classifier and the parser.
   localparam int FMSP_FIFO_DEPTH = 4;

   // Character codes that the parser recognizes.
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_SEVEN = 8'h37;
   localparam logic [7:0] CHAR_U     = 8'h75;
   localparam logic [7:0] CHAR_G     = 8'h67;
   localparam logic [7:0] CHAR_O     = 8'h6f;
   localparam logic [7:0] CHAR_A     = 8'h61;
   localparam logic [7:0] CHAR_PLUS  = 8'h2b;
   localparam logic [7:0] CHAR_MINUS = 8'h2d;
   localparam logic [7:0] CHAR_EQ    = 8'h3d;
   localparam logic [7:0] CHAR_R     = 8'h72;
   localparam logic [7:0] CHAR_W     = 8'h77;
   localparam logic [7:0] CHAR_X     = 8'h78;
   localparam logic [7:0] CHAR_BIG_X = 8'h58;
   localparam logic [7:0] CHAR_S     = 8'h73;
   localparam logic [7:0] CHAR_T     = 8'h74;
   localparam logic [7:0] CHAR_COMMA = 8'h2c;

   // Base mode of a symbolic string and the permission mask.
   localparam logic [11:0] MODE_BASE = 12'o0777;
   localparam logic [8:0]  WHO_ALL   = 9'o777;

   // Class of one character as seen by the symbolic parser.
   typedef enum logic [3:0] {
      CK_OTHER,
      CK_U,
      CK_G,
      CK_O,
      CK_A,
      CK_PLUS,
      CK_MINUS,
      CK_EQ,
      CK_R,
      CK_W,
      CK_X,
      CK_S,
      CK_T,
      CK_COMMA
   } char_kind_type;

   // Clause operator.
   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_SET = 2'd2
   } clause_op_type;

   // Parser phase within a clause.
   typedef enum logic {
      PH_WHO  = 1'b0,
      PH_PERM = 1'b1
   } parse_phase_type;

   // One classified character on its way from front to back.
   typedef struct packed {
      char_kind_type kind;
      logic          is_digit;
      logic [2:0]    digit;
      logic          is_last;
      logic          is_empty;
   } fmsp_item_type;

   // Copy one class of the clause-start mode into every named class.
   function automatic logic [8:0] class_copy(logic [8:0] from_mode, char_kind_type kind,
                                             logic [8:0] who);
      logic [2:0] g;
      logic [8:0] r;
      unique case (kind)
         CK_U:    g = from_mode[8:6];
         CK_G:    g = from_mode[5:3];
         default: g = from_mode[2:0];
      endcase
      r = '0;
      if (|who[8:6]) r[8:6] = g;
      if (|who[5:3]) r[5:3] = g;
      if (|who[2:0]) r[2:0] = g;
      return r;
   endfunction

   // Apply one finished clause to the mode.
   function automatic logic [11:0] apply_clause(logic [11:0] mode, logic [8:0] who,
                                                clause_op_type op, logic [8:0] perms,
                                                logic [2:0] special);
      logic [11:0] m;
      logic [11:0] set_bits;
      logic [11:0] clr_bits;
      m        = mode;
      set_bits = {special, perms};
      clr_bits = {|who[8:6], |who[5:3], |who[2:0], who};
      if (op == OP_SET) m = m & ~clr_bits;
      if (op == OP_SUB) m = m & ~set_bits;
      else              m = m | set_bits;
      return m;
   endfunction

endpackage

// ----- sv/file_mode_string_parser_core.sv -----
// Channel  | Ports              | Transaction contents
// ---------+--------------------+------------------------------------------------------
// request  | req_tvalid/tready  | tdata[7:0] char_code; tlast is_last; tuser[0] is_empty
// response | rsp_tvalid/tready  | tdata[31:0] mode_value; tuser[0] parse_ok, [1] was_octal
//
// One character per cycle is accepted at full rate unless the request side stalls;
// rsp_tvalid follows the last character through classifier register, queue and parser.
// The rate is set by the parser stage, which updates its clause state once per character.
// Reset is synchronous and active high and returns the parser to its base state.
// A queue between the classifier and the parser absorbs stalls on the response side;
// the request side stalls only when the queue and the classifier register are full.
module file_mode_string_parser_core #(
   parameter int FifoDepth = fmsp_pkg::FMSP_FIFO_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_code
   input  logic        req_tlast,
   input  logic [0:0]  req_tuser,   // [0] is_empty
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] mode_value
   output logic [1:0]  rsp_tuser    // [0] parse_ok, [1] was_octal
);
   import fmsp_pkg::*;

   logic          front_valid;
   logic          front_ready;
   fmsp_item_type front_item;
   logic          queue_valid;
   logic          queue_ready;
   fmsp_item_type queue_item;

   // Classifier.
   fmsp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .item_valid (front_valid),
      .item_ready (front_ready),
      .item       (front_item)
   );

   // Queue between classifier and parser.
   fmsp_fifo #(
      .Depth (FifoDepth)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_item   (front_item),
      .out_valid (queue_valid),
      .out_ready (queue_ready),
      .out_item  (queue_item)
   );

   // Parser and result register.
   fmsp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (queue_valid),
      .item_ready (queue_ready),
      .item       (queue_item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ----- sv/fmsp_front.sv -----
module fmsp_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,
   input  logic                   req_tlast,
   input  logic [0:0]             req_tuser,
   output logic                   item_valid,
   input  logic                   item_ready,
   output fmsp_pkg::fmsp_item_type item
);
   import fmsp_pkg::*;

   logic          valid_ff;
   logic          valid_in;
   fmsp_item_type item_ff;
   fmsp_item_type item_in;
   char_kind_type kind;
   logic          accept;

   // Classify the incoming character.
   always_comb begin
      unique case (req_tdata)
         CHAR_U:               kind = CK_U;
         CHAR_G:               kind = CK_G;
         CHAR_O:               kind = CK_O;
         CHAR_A:               kind = CK_A;
         CHAR_PLUS:            kind = CK_PLUS;
         CHAR_MINUS:           kind = CK_MINUS;
         CHAR_EQ:              kind = CK_EQ;
         CHAR_R:               kind = CK_R;
         CHAR_W:               kind = CK_W;
         CHAR_X, CHAR_BIG_X:   kind = CK_X;
         CHAR_S:               kind = CK_S;
         CHAR_T:               kind = CK_T;
         CHAR_COMMA:           kind = CK_COMMA;
         default:              kind = CK_OTHER;
      endcase
   end

   assign req_tready = !valid_ff || item_ready;
   assign accept     = req_tvalid && req_tready;

   // Build the classified item.
   always_comb begin
      item_in.kind     = kind;
      item_in.is_digit = (req_tdata >= CHAR_ZERO) && (req_tdata <= CHAR_SEVEN);
      item_in.digit    = req_tdata[2:0];
      item_in.is_last  = req_tlast;
      item_in.is_empty = req_tuser[0];
   end

   // Stage register holds one item until the queue takes it.
   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (item_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ----- sv/fmsp_fifo.sv -----
module fmsp_fifo #(
   parameter int Depth = fmsp_pkg::FMSP_FIFO_DEPTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  fmsp_pkg::fmsp_item_type in_item,
   output logic                    out_valid,
   input  logic                    out_ready,
   output fmsp_pkg::fmsp_item_type out_item
);
   import fmsp_pkg::*;

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   fmsp_item_type    mem_ff [Depth];
   logic [PtrW-1:0]  wr_ptr_ff;
   logic [PtrW-1:0]  wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff;
   logic [PtrW-1:0]  rd_ptr_in;
   logic [CntW-1:0]  count_ff;
   logic [CntW-1:0]  count_in;
   logic             push;
   logic             pop;

   assign in_ready  = count_ff != CntW'(Depth);
   assign out_valid = count_ff != '0;
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_item  = mem_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage write.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

// ----- sv/fmsp_back.sv -----
module fmsp_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    item_valid,
   output logic                    item_ready,
   input  fmsp_pkg::fmsp_item_type item,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [31:0]             rsp_tdata,
   output logic [1:0]              rsp_tuser
);
   import fmsp_pkg::*;

   // Parser state.
   logic [11:0]     sym_mode_ff, sym_mode_in;
   logic [8:0]      who_ff, who_in;
   clause_op_type   op_ff, op_in;
   logic [8:0]      start_ff, start_in;
   logic [8:0]      perms_ff, perms_in;
   logic [2:0]      special_ff, special_in;
   logic            saw_ff, saw_in;
   parse_phase_type phase_ff, phase_in;
   logic            err_ff, err_in;
   logic            all_oct_ff, all_oct_in;
   logic [63:0]     accum_ff, accum_in;
   logic            ovf_ff, ovf_in;

   // Values after the current character, before the end-of-string reset.
   logic [11:0]     sym_mode_s;
   logic [8:0]      who_s;
   clause_op_type   op_s;
   logic [8:0]      start_s;
   logic [8:0]      perms_s;
   logic [2:0]      special_s;
   logic            saw_s;
   parse_phase_type phase_s;
   logic            err_s;
   logic            all_oct_s;
   logic [63:0]     accum_s;
   logic            ovf_s;

   // Result register.
   logic            rsp_valid_ff, rsp_valid_in;
   logic            rsp_ok_ff, rsp_ok_in;
   logic [11:0]     rsp_mode_ff, rsp_mode_in;
   logic [31:0]     rsp_octal_ff, rsp_octal_in;
   logic            rsp_oct_ff, rsp_oct_in;

   logic            pop;
   logic            done;
   logic            is_who;
   logic            is_op;

   assign item_ready = !rsp_valid_ff || rsp_tready;
   assign pop        = item_valid && item_ready;
   assign done       = item.is_last || item.is_empty;
   assign is_who     = (item.kind == CK_U) || (item.kind == CK_G) ||
                       (item.kind == CK_O) || (item.kind == CK_A);
   assign is_op      = (item.kind == CK_PLUS) || (item.kind == CK_MINUS) ||
                       (item.kind == CK_EQ);

   // Phase: next state after the character, then back to who at end of string.
   always_comb begin
      phase_s = phase_ff;
      if (!err_ff) begin
         unique case (phase_ff)
            PH_WHO:  if (is_op) phase_s = PH_PERM;
            PH_PERM: if (item.kind == CK_COMMA) phase_s = PH_WHO;
            default: phase_s = PH_WHO;
         endcase
      end
   end

   always_comb begin
      if (pop && done) begin
         phase_in = PH_WHO;
      end else if (pop) begin
         phase_in = phase_s;
      end else begin
         phase_in = phase_ff;
      end
   end

   // Octal accumulation for every character.
   always_comb begin
      accum_s   = accum_ff;
      ovf_s     = ovf_ff;
      all_oct_s = all_oct_ff;
      if (item.is_digit) begin
         if (accum_ff[63:61] != 3'b000) ovf_s = 1'b1;
         accum_s = {accum_ff[60:0], item.digit};
      end else begin
         all_oct_s = 1'b0;
      end
   end

   // Symbolic clause parsing.
   always_comb begin
      sym_mode_s = sym_mode_ff;
      who_s      = who_ff;
      op_s       = op_ff;
      start_s    = start_ff;
      perms_s    = perms_ff;
      special_s  = special_ff;
      saw_s      = saw_ff;
      err_s      = err_ff;
      if (!err_ff) begin
         if (phase_ff == PH_WHO) begin
            priority case (1'b1)
               is_who: begin
                  unique case (item.kind)
                     CK_U:    who_s = who_ff | 9'o700;
                     CK_G:    who_s = who_ff | 9'o070;
                     CK_O:    who_s = who_ff | 9'o007;
                     default: who_s = who_ff | WHO_ALL;
                  endcase
                  saw_s = 1'b1;
               end
               is_op: begin
                  unique case (item.kind)
                     CK_MINUS: op_s = OP_SUB;
                     CK_EQ:    op_s = OP_SET;
                     default:  op_s = OP_ADD;
                  endcase
                  if (who_ff == '0) who_s = WHO_ALL;
                  start_s   = sym_mode_ff[8:0];
                  perms_s   = '0;
                  special_s = '0;
               end
               default: err_s = 1'b1;
            endcase
         end else begin
            unique case (item.kind)
               CK_R: perms_s = perms_ff | (who_ff & 9'o444);
               CK_W: perms_s = perms_ff | (who_ff & 9'o222);
               CK_X: perms_s = perms_ff | (who_ff & 9'o111);
               CK_S: begin
                  special_s[2] = special_ff[2] | (|who_ff[8:6]);
                  special_s[1] = special_ff[1] | (|who_ff[5:3]);
               end
               CK_T: special_s[0] = 1'b1;
               CK_U, CK_G, CK_O: begin
                  perms_s = perms_ff | class_copy(start_ff, item.kind, who_ff);
               end
               CK_COMMA: begin
                  sym_mode_s = apply_clause(sym_mode_ff, who_ff, op_ff, perms_ff,
                                            special_ff);
                  who_s      = '0;
                  saw_s      = 1'b0;
               end
               default: err_s = 1'b1;
            endcase
         end
      end
   end

   // State update: the end of a string returns everything to the base state.
   always_comb begin
      if (pop && done) begin
         sym_mode_in = MODE_BASE;
         who_in      = '0;
         op_in       = OP_ADD;
         start_in    = '0;
         perms_in    = '0;
         special_in  = '0;
         saw_in      = 1'b0;
         err_in      = 1'b0;
         all_oct_in  = 1'b1;
         accum_in    = '0;
         ovf_in      = 1'b0;
      end else if (pop) begin
         sym_mode_in = sym_mode_s;
         who_in      = who_s;
         op_in       = op_s;
         start_in    = start_s;
         perms_in    = perms_s;
         special_in  = special_s;
         saw_in      = saw_s;
         err_in      = err_s;
         all_oct_in  = all_oct_s;
         accum_in    = accum_s;
         ovf_in      = ovf_s;
      end else begin
         sym_mode_in = sym_mode_ff;
         who_in      = who_ff;
         op_in       = op_ff;
         start_in    = start_ff;
         perms_in    = perms_ff;
         special_in  = special_ff;
         saw_in      = saw_ff;
         err_in      = err_ff;
         all_oct_in  = all_oct_ff;
         accum_in    = accum_ff;
         ovf_in      = ovf_ff;
      end
   end

   // Result of the string that ends with this character.
   always_comb begin
      rsp_ok_in    = 1'b0;
      rsp_oct_in   = 1'b0;
      rsp_mode_in  = '0;
      rsp_octal_in = '0;
      if (!item.is_empty) begin
         if (all_oct_s) begin
            if (!ovf_s) begin
               rsp_ok_in    = 1'b1;
               rsp_oct_in   = 1'b1;
               rsp_octal_in = accum_s[31:0];
            end
         end else if (!err_s) begin
            if (phase_s == PH_PERM) begin
               rsp_ok_in   = 1'b1;
               rsp_mode_in = apply_clause(sym_mode_s, who_s, op_s, perms_s, special_s);
            end else if (!saw_s) begin
               rsp_ok_in   = 1'b1;
               rsp_mode_in = sym_mode_s;
            end
         end
      end
   end

   always_comb begin
      if (pop && done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         sym_mode_ff  <= MODE_BASE;
         who_ff       <= '0;
         op_ff        <= OP_ADD;
         start_ff     <= '0;
         perms_ff     <= '0;
         special_ff   <= '0;
         saw_ff       <= 1'b0;
         phase_ff     <= PH_WHO;
         err_ff       <= 1'b0;
         all_oct_ff   <= 1'b1;
         accum_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sym_mode_ff  <= sym_mode_in;
         who_ff       <= who_in;
         op_ff        <= op_in;
         start_ff     <= start_in;
         perms_ff     <= perms_in;
         special_ff   <= special_in;
         saw_ff       <= saw_in;
         phase_ff     <= phase_in;
         err_ff       <= err_in;
         all_oct_ff   <= all_oct_in;
         accum_ff     <= accum_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload is loaded only when a string ends.
   always_ff @(posedge clock) begin
      if (pop && done) begin
         rsp_ok_ff    <= rsp_ok_in;
         rsp_oct_ff   <= rsp_oct_in;
         rsp_mode_ff  <= rsp_mode_in;
         rsp_octal_ff <= rsp_octal_in;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_oct_ff ? rsp_octal_ff : {20'd0, rsp_mode_ff};
   assign rsp_tuser[0] = rsp_ok_ff;
   assign rsp_tuser[1] = rsp_oct_ff;

   // A finished string never overwrites a result that is still waiting.
   assert property (@(posedge clock) disable iff (reset)
      !(pop && done && rsp_valid_ff && !rsp_tready))
      else $error("result overwritten before transfer");

   // A failed parse carries a zero mode and no octal flag.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ok_ff |-> rsp_tdata == '0 && !rsp_oct_ff)
      else $error("error result with nonzero payload");

   // After a string ends the parser is back in its base state.
   assert property (@(posedge clock) disable iff (reset)
      pop && done |=> phase_ff == PH_WHO && !err_ff && all_oct_ff &&
                      accum_ff == '0 && sym_mode_ff == MODE_BASE)
      else $error("parser state not restored after end of string");

   // The symbolic parser keeps its phase once it has failed, until the string ends.
   assert property (@(posedge clock) disable iff (reset)
      err_ff && !(pop && done) |=> phase_ff == $past(phase_ff))
      else $error("phase moved after a parse error");

endmodule
